[sv/bfa_pkg.sv]
// Shared types and codes for the bitmap frame allocator.
package bfa_pkg;
  localparam int KIND_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 14;
  localparam int ADDR_W = 32;
  localparam int FADDR_W = 25;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3FFF;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MARK_ALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MARK_USED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MARK_FREE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SEAL = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  localparam logic CFG_TRACKED = 1'b0;
  localparam logic CFG_RESERVE = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture request and limits
    logic clr_ptr;   // restart the word pointer
    logic step;      // process one map word
    logic finish;    // apply result and count
    logic init_step; // one word of the fill sweep
  } bfa_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last_word;
    logic hit;
    logic scan_kind;
  } bfa_stat_t;
endpackage

[sv/bitmap_frame_allocator_unit.sv]
// Top level of the bitmap frame allocator.
// Requests arrive on the s_axis channel: tuser carries the kind, tdata the
// byte address (bits 31:0) and range length (bits 63:32). One result item
// per request leaves on m_axis with status, frame address and the counts.
// Configuration writes (index 0 tracked frames, index 1 reserved frames)
// are taken on cfg_valid/cfg_ready at any time; a request works with the
// limits present when it is accepted.
// The frame map lives in a memory of 64-bit words, one word read and one
// written per cycle; a request walks the words in order, so range marking,
// mark all and seal visit every word of the map, while alloc stops after
// the word holding the first free frame, free touches one word.
// After reset the map is filled with ones, a word at a time, during
// which no request is accepted; the count resets to zero.
// A result waits in its register until m_axis_tready; no new request is
// taken until then.
module bitmap_frame_allocator_unit #(
  parameter int MAX_FRAMES = 8192,
  parameter int FRAME_BYTES = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // address[31:0], length[63:32]
  input  logic [2:0] s_axis_tuser,   // kind
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [55:0] m_axis_tdata, // status[1:0], frame_address[26:2],
                                    // used_count[40:27], free_count[54:41]
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [13:0] cfg_data
);
  import bfa_pkg::*;

  bfa_cmd_t cmd;
  bfa_stat_t stat;
  logic [13:0] tracked_frames, reserve_frames;
  logic [1:0] status;
  logic [24:0] frame_address;
  logic [13:0] used_count, free_count;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_frames <= 14'd8192;
      reserve_frames <= 14'd256;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TRACKED) tracked_frames <= cfg_data;
      else reserve_frames <= cfg_data;
    end
  end

  bfa_ctrl #(.MAX_FRAMES(MAX_FRAMES)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .stat(stat), .cmd(cmd), .kind(s_axis_tuser)
  );

  bfa_datapath #(.MAX_FRAMES(MAX_FRAMES), .FRAME_BYTES(FRAME_BYTES)) u_dp (
    .clk(clk), .cmd(cmd), .stat(stat), .rst(rst),
    .kind(s_axis_tuser), .address(s_axis_tdata[31:0]), .length(s_axis_tdata[63:32]),
    .tracked_frames(tracked_frames), .reserve_frames(reserve_frames),
    .status(status), .frame_address(frame_address),
    .used_count(used_count), .free_count(free_count)
  );

  assign m_axis_tdata = {1'b0, free_count, used_count, frame_address, status};
endmodule

[sv/bfa_datapath.sv]
// Map memory, word scanner, counters and result register of the allocator.
module bfa_datapath #(
  parameter int MAX_FRAMES = 8192,
  parameter int FRAME_BYTES = 4096
) (
  input  logic clk,
  input  bfa_pkg::bfa_cmd_t cmd,
  output bfa_pkg::bfa_stat_t stat,
  input  logic rst,
  input  logic [2:0] kind,
  input  logic [31:0] address,
  input  logic [31:0] length,
  input  logic [13:0] tracked_frames,
  input  logic [13:0] reserve_frames,
  output logic [1:0] status,
  output logic [24:0] frame_address,
  output logic [13:0] used_count,
  output logic [13:0] free_count
);
  import bfa_pkg::*;

  localparam int WORDS = (MAX_FRAMES + 63) / 64;
  localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW = $clog2(MAX_FRAMES) + 1;
  localparam int SH = $clog2(FRAME_BYTES);
  localparam int PW = WA + 6;

  logic [63:0] mem [WORDS];
  logic [63:0] rd;
  logic [WA-1:0] ptr;
  logic [WA-1:0] rptr;
  logic rvalid;
  logic [KIND_W-1:0] k;
  logic [FW-1:0] lo, hi, trk, rsv;
  logic [ADDR_W-1:0] fr_idx;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W:0] acc;
  logic found;
  logic [PW-1:0] found_f;
  logic [1:0] st;
  logic [FADDR_W-1:0] fa;
  logic free_was_set;

  function automatic logic [FW-1:0] clamp(input logic [13:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(MAX_FRAMES)) return FW'(MAX_FRAMES);
    return FW'(w);
  endfunction

  // Range bounds and clamped limits, captured at load.
  logic [32:0] endb;
  logic [33:0] lastb;
  logic [32:0] firstf;
  always_comb begin
    endb = {1'b0, address} + {1'b0, length};
    lastb = ({1'b0, endb} + 34'(FRAME_BYTES - 1)) >> SH;
    firstf = 33'(address >> SH);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k <= kind;
      trk <= clamp(tracked_frames);
      rsv <= clamp(reserve_frames);
      fr_idx <= address >> SH;
      if (kind == KIND_SEAL) begin
        lo <= '0;
        hi <= (clamp(reserve_frames) < clamp(tracked_frames)) ?
              clamp(reserve_frames) : clamp(tracked_frames);
      end else if (kind == KIND_ALLOC) begin
        lo <= clamp(reserve_frames);
        hi <= clamp(tracked_frames);
      end else begin
        lo <= (firstf > 33'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(firstf);
        hi <= (lastb > 34'(clamp(tracked_frames))) ? clamp(tracked_frames) : FW'(lastb);
      end
    end
  end

  // Per-word mask of frames in [lo, hi).
  logic [63:0] mask, tmask;
  logic [63:0] wr;
  logic [5:0] ffs;
  logic anyf;
  logic [COUNT_W:0] pc;
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      mask[i] = (FW'({rptr, 6'(i)}) >= lo) && (FW'({rptr, 6'(i)}) < hi);
      tmask[i] = FW'({rptr, 6'(i)}) < trk;
    end
    anyf = 1'b0;
    ffs = '0;
    for (int i = 63; i >= 0; i--) begin
      if (mask[i] && !rd[i]) begin
        anyf = 1'b1;
        ffs = 6'(i);
      end
    end
    pc = '0;
    for (int i = 0; i < 64; i++) pc = pc + (COUNT_W+1)'(rd[i] & tmask[i]);
    case (k)
      KIND_ALLOC: begin
        wr = rd;
        wr[ffs] = 1'b1;
      end
      KIND_FREE: begin
        wr = rd;
        wr[fr_idx[5:0]] = 1'b0;
      end
      KIND_MARK_FREE: wr = rd & ~mask;
      default: wr = rd | mask;
    endcase
  end

  // Read pointer advances each step; the read word is registered and arrives in the next cycle.
  logic do_write;
  always_comb begin
    do_write = 1'b0;
    if (rvalid) begin
      case (k)
        KIND_ALLOC: do_write = anyf && !found;
        KIND_FREE: do_write = 1'b1;
        KIND_MARK_ALL, KIND_MARK_USED, KIND_MARK_FREE, KIND_SEAL: do_write = 1'b1;
        default: do_write = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step) mem[ptr] <= '1;
    else if (do_write) mem[rptr] <= (k == KIND_MARK_ALL) ? '1 : wr;
    rd <= mem[ptr];
  end

  logic [WA-1:0] free_word;
  assign free_word = fr_idx[WA+5:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      rvalid <= 1'b0;
      cnt <= '0;
      found <= 1'b0;
    end else begin
      rvalid <= cmd.step;
      if (cmd.step) rptr <= ptr;
      if (cmd.init_step) ptr <= ptr + 1'b1;
      else if (cmd.clr_ptr) ptr <= (kind == KIND_FREE) ?
          WA'((address >> SH) >> 6) : '0;
      else if (cmd.step) ptr <= ptr + 1'b1;
      if (cmd.load) begin
        found <= 1'b0;
        acc <= '0;
        free_was_set <= 1'b0;
      end
      if (rvalid) begin
        if (k == KIND_ALLOC && anyf && !found) begin
          found <= 1'b1;
          found_f <= {rptr, ffs};
        end
        if (k == KIND_FREE) free_was_set <= rd[fr_idx[5:0]];
        if (k == KIND_SEAL) acc <= acc + pc + (COUNT_W+1)'($countones(mask & ~rd & tmask));
      end
      if (cmd.finish) begin
        case (k)
          KIND_ALLOC: begin
            if (found && (cnt < COUNT_W'(trk))) begin
              st <= ST_DONE;
              fa <= FADDR_W'(32'(found_f) << SH);
              if (cnt < COUNT_MAX) cnt <= cnt + 1'b1;
            end else begin
              st <= ST_NO_FRAME;
              fa <= '0;
            end
          end
          KIND_FREE: begin
            fa <= '0;
            // A frame in the reserved area or beyond the tracked limit is ignored.
            if (fr_idx < 32'(rsv) || fr_idx >= 32'(trk)) st <= ST_IGNORED;
            else begin
              st <= ST_DONE;
              if (free_was_set && cnt != '0) cnt <= cnt - 1'b1;
            end
          end
          KIND_SEAL: begin
            st <= ST_DONE;
            fa <= '0;
            cnt <= (acc > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(acc);
          end
          KIND_MARK_ALL, KIND_MARK_USED, KIND_MARK_FREE: begin
            st <= ST_DONE;
            fa <= '0;
          end
          default: begin
            st <= ST_IGNORED;
            fa <= '0;
          end
        endcase
      end
    end
  end

  // Alloc only writes when the count allows it: gate is applied by scan
  // being skipped in the controller when the used count has reached the tracked limit.
  logic scan;
  always_comb begin
    scan = 1'b0;
    case (kind)
      KIND_ALLOC: scan = cnt < COUNT_W'(clamp(tracked_frames));
      KIND_FREE: scan = !(32'(address >> SH) < 32'(clamp(reserve_frames)) ||
                          32'(address >> SH) >= 32'(clamp(tracked_frames)));
      KIND_MARK_ALL, KIND_MARK_USED, KIND_MARK_FREE, KIND_SEAL: scan = 1'b1;
      default: scan = 1'b0;
    endcase
  end

  assign stat.scan_kind = scan;
  assign stat.hit = found || (rvalid && k == KIND_ALLOC && anyf);
  assign stat.last_word = (k == KIND_FREE) ? (ptr == free_word) :
                          (ptr == WA'(WORDS - 1));
  assign status = st;
  assign frame_address = fa;
  assign used_count = cnt;
  assign free_count = (COUNT_W'(trk) > cnt) ? COUNT_W'(trk) - cnt : '0;
endmodule

[sv/bfa_ctrl.sv]
// Sequencer for the allocator: fill sweep, request scan and result handshake.
module bfa_ctrl #(
  parameter int MAX_FRAMES = 8192
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  bfa_pkg::bfa_stat_t stat,
  output bfa_pkg::bfa_cmd_t cmd,
  input  logic [2:0] kind
);
  import bfa_pkg::*;

  localparam int WORDS = (MAX_FRAMES + 63) / 64;
  localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DONE = 6'b010000,
    S_OUT = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [WA-1:0] icnt;
  logic alloc_scan;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      icnt <= '0;
      alloc_scan <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) icnt <= icnt + 1'b1;
      if (cmd.load) alloc_scan <= (kind == KIND_ALLOC);
    end
  end

  // One map word per cycle; an alloc stops once a free frame is seen.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (icnt == WA'(WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.clr_ptr = 1'b1;
          state_next = stat.scan_kind ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (alloc_scan && stat.hit) state_next = S_DRAIN;
        else begin
          cmd.step = 1'b1;
          if (stat.last_word) state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
